/* src/smv_pkg.sv */
// shared types, sizes and codes of the sparse matrix-vector multiply core
// no dependencies
`default_nettype none
package smv_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;
   localparam int MAX_ENTRIES = 1024;

   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int DIM_W     = 7;
   localparam int CNT_W     = 11;
   localparam int POS_W     = ROW_W + COL_W;
   localparam int MEM_DEPTH = 1 << POS_W;
   localparam int VAL_W     = 32;
   localparam int SUM_W     = 64;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;
   localparam int QPTR_W    = $clog2(CMD_DEPTH);
   localparam int RPTR_W    = $clog2(RSP_DEPTH);
   localparam int QCNT_W    = $clog2(CMD_DEPTH + 1);
   localparam int RCNT_W    = $clog2(RSP_DEPTH + 1);

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_VEC = 2'd1,
      ACT_CLR = 2'd2,
      ACT_RUN = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_ACK,
      OP_ADD,
      OP_VEC,
      OP_CLR,
      OP_RUN
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         col;
      logic signed [VAL_W-1:0]  value;
      status_type               status;
      logic [DIM_W-1:0]         nr;
      logic [DIM_W-1:0]         nc;
   } cmd_type;

   typedef struct packed {
      logic [ROW_W-1:0]         row_index;
      logic signed [SUM_W-1:0]  sum;
      logic                     last;
      status_type               status;
   } rsp_type;

   typedef struct packed {
      logic                     init_busy;
      logic [RCNT_W-1:0]        rsp_count;
   } bk_stat_type;

   // register value clamped to [1, m]
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                                input logic [DIM_W-1:0] m);
      if (r == '0) begin
         return DIM_W'(1);
      end else if (r > m) begin
         return m;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/smv_front.sv */
// front end: classifies request items and queues commands for the back end
// depends on smv_pkg
`default_nettype none
module smv_front
   import smv_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   output logic                         full,
   input  wire logic [1:0]              req_action,
   input  wire logic [ROW_W-1:0]        req_row,
   input  wire logic [COL_W-1:0]        req_col,
   input  wire logic signed [VAL_W-1:0] req_value,
   input  wire logic [DIM_W-1:0]        nr_reg,
   input  wire logic [DIM_W-1:0]        nc_reg,
   output cmd_type                      cmd,
   output logic                         cmd_valid,
   input  wire logic                    cmd_take
);

   cmd_type             q_ff [CMD_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   cmd_type             cls;
   logic [DIM_W-1:0]    nr, nc;
   logic                do_push, do_pop;

   // classify
   always_comb begin
      nr         = eff_dim(nr_reg, DIM_W'(MAX_ROWS));
      nc         = eff_dim(nc_reg, DIM_W'(MAX_COLS));
      cls.row    = req_row;
      cls.col    = req_col;
      cls.value  = req_value;
      cls.nr     = nr;
      cls.nc     = nc;
      cls.status = ST_OK;
      cls.op     = OP_ACK;
      unique case (action_type'(req_action))
         ACT_ADD: begin
            if ({1'b0, req_row} >= nr || {1'b0, req_col} >= nc) begin
               cls.status = ST_RANGE;
            end else begin
               cls.op = OP_ADD;
            end
         end
         ACT_VEC: begin
            if ({1'b0, req_col} >= nc) begin
               cls.status = ST_RANGE;
            end else begin
               cls.op = OP_VEC;
            end
         end
         ACT_CLR: cls.op = OP_CLR;
         ACT_RUN: cls.op = OP_RUN;
         default: cls.op = OP_ACK;
      endcase
   end

   assign full      = (cnt_ff == QCNT_W'(CMD_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

/* src/smv_back.sv */
// back end: entry memory, vector store, row dot products and result queue
// depends on smv_pkg
`default_nettype none
module smv_back
   import smv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  cmd_type      cmd,
   input  wire logic    cmd_valid,
   output logic         cmd_take,
   output rsp_type      rsp,
   output logic         empty,
   input  wire logic    pop,
   output bk_stat_type  bk_stat
);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_ADD, S_CLR, S_ACK, S_RUN_ISSUE, S_RUN_DRAIN, S_RUN_PUSH
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cur_ff, cur_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [POS_W-1:0]        sweep_ff, sweep_in;
   logic [ROW_W-1:0]        k_ff, k_in;
   logic [COL_W-1:0]        c_ff, c_in;

   // entry memory: valid bit and value per matrix position
   logic [VAL_W:0]          mem [MEM_DEPTH];
   logic [VAL_W:0]          mrd_ff;
   logic                    mrd_en, mwr_en;
   logic [POS_W-1:0]        mrd_addr, mwr_addr;
   logic [VAL_W:0]          mwr_data;

   // vector store, zeroed by the clearing pass after reset
   logic signed [VAL_W-1:0] vec_ff [MAX_COLS];
   logic signed [VAL_W-1:0] vdat_ff;
   logic                    vec_we;
   logic [COL_W-1:0]        vec_waddr;
   logic signed [VAL_W-1:0] vec_wdata;

   // product pipeline
   logic                    issue, issue_last, clr_acc;
   logic                    p1_vld_ff, p1_last_ff;
   logic                    p2_vld_ff, p2_last_ff;
   logic signed [SUM_W-1:0] prod_ff, prod_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic                    row_done_ff, row_done_in;

   // result queue
   rsp_type                 rq_ff [RSP_DEPTH];
   logic [RPTR_W-1:0]       rwr_ff, rrd_ff;
   logic [RCNT_W-1:0]       rcnt_ff;
   logic                    rsp_push, rsp_pop, rsp_space;
   rsp_type                 rsp_data;

   logic [DIM_W-1:0]        nc_m1, nr_m1;

   function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
      logic signed [SUM_W-1:0] s;
      s = a + b;
      if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
         s = b[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end
      return s;
   endfunction

   function automatic rsp_type ack(input status_type st);
      rsp_type r;
      r.row_index = '0;
      r.sum       = '0;
      r.last      = 1'b1;
      r.status    = st;
      return r;
   endfunction

   assign rsp_space = (rcnt_ff != RCNT_W'(RSP_DEPTH));
   assign nc_m1     = cur_ff.nc - DIM_W'(1);
   assign nr_m1     = cur_ff.nr - DIM_W'(1);

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      cnt_in     = cnt_ff;
      sweep_in   = sweep_ff;
      k_in       = k_ff;
      c_in       = c_ff;
      cmd_take   = 1'b0;
      rsp_push   = 1'b0;
      rsp_data   = ack(ST_OK);
      mrd_en     = 1'b0;
      mrd_addr   = {k_ff, c_ff};
      mwr_en     = 1'b0;
      mwr_addr   = sweep_ff;
      mwr_data   = '0;
      vec_we     = 1'b0;
      vec_waddr  = cmd.col;
      vec_wdata  = cmd.value;
      issue      = 1'b0;
      issue_last = 1'b0;
      clr_acc    = 1'b0;
      unique case (state_ff)
         S_INIT, S_CLR: begin
            mwr_en   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            // the pass after reset also zeroes the vector
            if (state_ff == S_INIT) begin
               vec_we    = 1'b1;
               vec_waddr = sweep_ff[COL_W-1:0];
               vec_wdata = '0;
            end
            if (sweep_ff == POS_W'(MEM_DEPTH - 1)) begin
               state_in = (state_ff == S_CLR) ? S_ACK : S_IDLE;
            end
         end
         S_ACK: begin
            if (rsp_space) begin
               rsp_push = 1'b1;
               rsp_data = ack(cur_ff.status);
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  OP_ACK: begin
                     if (rsp_space) begin
                        cmd_take = 1'b1;
                        rsp_push = 1'b1;
                        rsp_data = ack(cmd.status);
                     end
                  end
                  OP_VEC: begin
                     if (rsp_space) begin
                        cmd_take = 1'b1;
                        vec_we   = 1'b1;
                        rsp_push = 1'b1;
                        rsp_data = ack(ST_OK);
                     end
                  end
                  OP_CLR: begin
                     cmd_take = 1'b1;
                     cur_in   = cmd;
                     cnt_in   = '0;
                     sweep_in = '0;
                     state_in = S_CLR;
                  end
                  OP_ADD: begin
                     cmd_take = 1'b1;
                     cur_in   = cmd;
                     mrd_en   = 1'b1;
                     mrd_addr = {cmd.row, cmd.col};
                     state_in = S_ADD;
                  end
                  OP_RUN: begin
                     if (cnt_ff == '0) begin
                        if (rsp_space) begin
                           cmd_take = 1'b1;
                           rsp_push = 1'b1;
                           rsp_data = ack(ST_EMPTY);
                        end
                     end else begin
                        cmd_take = 1'b1;
                        cur_in   = cmd;
                        k_in     = '0;
                        c_in     = '0;
                        clr_acc  = 1'b1;
                        state_in = S_RUN_ISSUE;
                     end
                  end
                  default: cmd_take = 1'b0;
               endcase
            end
         end
         S_ADD: begin
            // existing position is replaced, a new one needs room
            if (rsp_space) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
               mwr_addr = {cur_ff.row, cur_ff.col};
               mwr_data = {1'b1, cur_ff.value};
               if (mrd_ff[VAL_W]) begin
                  mwr_en = 1'b1;
               end else if (cnt_ff == CNT_W'(MAX_ENTRIES)) begin
                  rsp_data = ack(ST_FULL);
               end else begin
                  mwr_en = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_RUN_ISSUE: begin
            mrd_en     = 1'b1;
            issue      = 1'b1;
            issue_last = ({1'b0, c_ff} == nc_m1);
            if (issue_last) begin
               c_in     = '0;
               state_in = S_RUN_DRAIN;
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         S_RUN_DRAIN: begin
            if (row_done_ff) begin
               state_in = S_RUN_PUSH;
            end
         end
         S_RUN_PUSH: begin
            if (rsp_space) begin
               rsp_push           = 1'b1;
               rsp_data.row_index = k_ff;
               rsp_data.sum       = acc_ff;
               rsp_data.last      = ({1'b0, k_ff} == nr_m1);
               rsp_data.status    = ST_OK;
               if (rsp_data.last) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  clr_acc  = 1'b1;
                  state_in = S_RUN_ISSUE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= '0;
         sweep_ff <= '0;
         k_ff     <= '0;
         c_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sweep_ff <= sweep_in;
         k_ff     <= k_in;
         c_ff     <= c_in;
      end
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (mwr_en) begin
         mem[mwr_addr] <= mwr_data;
      end
      if (mrd_en) begin
         mrd_ff <= mem[mrd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_ff[vec_waddr] <= vec_wdata;
      end
      if (issue) begin
         vdat_ff <= vec_ff[c_ff];
      end
   end

   always_comb begin
      prod_in = '0;
      if (mrd_ff[VAL_W]) begin
         prod_in = $signed(mrd_ff[VAL_W-1:0]) * vdat_ff;
      end
      acc_in      = acc_ff;
      row_done_in = row_done_ff;
      if (clr_acc) begin
         acc_in      = '0;
         row_done_in = 1'b0;
      end else if (p2_vld_ff) begin
         acc_in      = sat_add(acc_ff, prod_ff);
         row_done_in = p2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff   <= 1'b0;
         p2_vld_ff   <= 1'b0;
         row_done_ff <= 1'b0;
      end else begin
         p1_vld_ff   <= issue;
         p2_vld_ff   <= p1_vld_ff;
         row_done_ff <= row_done_in;
      end
      p1_last_ff <= issue_last;
      p2_last_ff <= p1_last_ff;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
   end

   assign rsp_pop = pop && (rcnt_ff != '0);
   assign empty   = (rcnt_ff == '0);
   assign rsp     = rq_ff[rrd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rwr_ff  <= '0;
         rrd_ff  <= '0;
         rcnt_ff <= '0;
      end else begin
         if (rsp_push) begin
            rwr_ff <= rwr_ff + 1'b1;
         end
         if (rsp_pop) begin
            rrd_ff <= rrd_ff + 1'b1;
         end
         rcnt_ff <= rcnt_ff + RCNT_W'(rsp_push) - RCNT_W'(rsp_pop);
      end
      if (rsp_push) begin
         rq_ff[rwr_ff] <= rsp_data;
      end
   end

   assign bk_stat.init_busy = (state_ff == S_INIT);
   assign bk_stat.rsp_count = rcnt_ff;

endmodule
`default_nettype wire

/* src/sparse_matrix_vector_multiply_core.sv */
// sparse matrix-vector multiply core
// a run does one entry memory read per column of each row
// a clear item sweeps the 4096-position entry memory, then sends its ack
// after reset a clearing pass zeroes entries and vector; items queue up meanwhile
// reset is synchronous, active high; registers return to 64 rows and 64 columns
// depends on smv_pkg, smv_front, smv_back
`default_nettype none
module sparse_matrix_vector_multiply_core
   import smv_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // configuration port
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [2:0]              paddr,
   input  wire logic [31:0]             pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   // request items
   input  wire logic                    push,
   output logic                         full,
   input  wire logic [1:0]              req_action,
   input  wire logic [ROW_W-1:0]        req_row,
   input  wire logic [COL_W-1:0]        req_col,
   input  wire logic signed [VAL_W-1:0] req_value,
   // result items
   output logic                         empty,
   input  wire logic                    pop,
   output logic [ROW_W-1:0]             rsp_row_index,
   output logic signed [SUM_W-1:0]      rsp_sum,
   output logic                         rsp_last,
   output logic [1:0]                   rsp_status
);

   logic [DIM_W-1:0] nr_ff, nr_in;
   logic [DIM_W-1:0] nc_ff, nc_in;
   logic             csr_wr;
   cmd_type          cmd;
   logic             cmd_valid, cmd_take;
   rsp_type          rsp;
   bk_stat_type      bk_stat;

   // register writes decode on the word address bit only
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      nr_in = nr_ff;
      nc_in = nc_ff;
      if (csr_wr) begin
         if (paddr[2]) begin
            nc_in = pwdata[DIM_W-1:0];
         end else begin
            nr_in = pwdata[DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nr_ff <= DIM_W'(MAX_ROWS);
         nc_ff <= DIM_W'(MAX_COLS);
      end else begin
         nr_ff <= nr_in;
         nc_ff <= nc_in;
      end
   end

   // misaligned reads return zero
   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'b00) begin
         prdata = paddr[2] ? {{(32-DIM_W){1'b0}}, nc_ff} : {{(32-DIM_W){1'b0}}, nr_ff};
      end
   end

   // front: range checks against the clamped sizes, command queue
   smv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_action (req_action),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_value  (req_value),
      .nr_reg     (nr_ff),
      .nc_reg     (nc_ff),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_take   (cmd_take)
   );

   // back: entry memory, vector, dot products and result queue
   smv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .rsp       (rsp),
      .empty     (empty),
      .pop       (pop),
      .bk_stat   (bk_stat)
   );

   assign rsp_row_index = rsp.row_index;
   assign rsp_sum       = rsp.sum;
   assign rsp_last      = rsp.last;
   assign rsp_status    = rsp.status;

   // back end never takes a command that is not there
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid)
      else $error("command taken from empty queue");

   // no command is carried out during the clearing pass
   a_init_hold: assert property (@(posedge clock) disable iff (reset)
      bk_stat.init_busy |-> !cmd_take)
      else $error("command taken during clearing pass");

   // result queue never overfills
   a_rsp_bound: assert property (@(posedge clock) disable iff (reset)
      bk_stat.rsp_count <= RCNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   // no result is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result pending after reset");

endmodule
`default_nettype wire
